>>> rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg: shared definitions for the RLE pattern decoder
// Character codes, result widths, scan modes and small character classifiers.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // Widths of the channel payloads; these are fixed by the stream format.
  localparam int CH_W        = 8;
  localparam int RUN_COORD_W = 32;
  localparam int RUN_LEN_W   = 16;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Character codes that the decoder reacts to.
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_B      = 8'h62;
  localparam logic [CH_W-1:0] CH_O      = 8'h6F;

  // Result kinds.
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Scanner mode; the unused code behaves as MODE_IDLE.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_COUNT   = 2'd2
  } scan_mode_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_token(input logic [CH_W-1:0] c);
    return c inside {CH_B, CH_O, CH_DOLLAR, CH_BANG};
  endfunction

endpackage

>>> rtl/rpd_in_if.sv
// ----------------------------------------------------------------------------
// rpd_in_if: input character channel
// Valid/ready channel that carries one pattern text byte per beat.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  import rpd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);

endinterface

>>> rtl/rpd_out_if.sv
// ----------------------------------------------------------------------------
// rpd_out_if: decoded result channel
// Valid/ready channel that carries one live run or end marker per beat.
// ----------------------------------------------------------------------------
interface rpd_out_if;
  import rpd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [RUN_COORD_W-1:0] run_x;
  logic [RUN_COORD_W-1:0] run_y;
  logic [RUN_LEN_W-1:0]   run_length;

  modport source (output valid, output kind, output run_x, output run_y,
                  output run_length, input ready);
  modport sink   (input valid, input kind, input run_x, input run_y,
                  input run_length, output ready);

endinterface

>>> rtl/rle_pattern_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_pattern_decoder_core: run-length-encoded cell pattern decoder
// Turns a stream of pattern text bytes into live cell runs and end markers.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per beat and answers with at most one result
// beat per byte. It sustains one byte per clock cycle while the result is not
// stalled: every byte is decoded in the cycle it is accepted, by a single pass
// of logic that updates the scanner state (mode, run count, column, row,
// finished flag) and loads the result register. The result register parts the
// two channels, so a new byte is taken whenever that register is empty or being
// drained in the same cycle; a stalled result therefore holds the input for as
// long as it stays. A live run result is registered and appears in the cycle
// after its 'o' byte is accepted. Whitespace is skipped, decimal digits build a
// saturating run count (an absent or zero count means one), and any other byte
// between tokens that is not a command opens a comment up to its newline. 'b'
// moves the column, 'o' emits a run and moves the column, '$' moves the row and
// zeroes the column, and '!' or a NUL byte ends the pattern with an end beat.
// After the end, bytes are ignored until a NUL, which clears all state
// silently. There is no memory and no clearing pass.
// ----------------------------------------------------------------------------
module rle_pattern_decoder_core #(
  parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,  // cursor width, 8 to 64
  parameter int COUNT_BITS = rpd_pkg::COUNT_BITS_DEF   // run count width, 4 to 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rpd_in_if.sink    in_chan,
  rpd_out_if.source out_chan
);
  import rpd_pkg::*;

  // The run count times ten plus a digit fits in four more bits.
  localparam int MUL_W = COUNT_BITS + 4;
  // Width used when capping the count to the result's run length field.
  localparam int LEN_CMP_W = (COUNT_BITS > RUN_LEN_W) ? COUNT_BITS : RUN_LEN_W;

  // Scanner state.
  scan_mode_t              mode_r,     mode_nxt;
  logic [COUNT_BITS-1:0]   count_r,    count_nxt;
  logic [COORD_BITS-1:0]   col_r,      col_nxt;
  logic [COORD_BITS-1:0]   row_r,      row_nxt;
  logic                    finished_r, finished_nxt;

  // Result register.
  logic                    out_valid_r;
  logic                    kind_r,     kind_nxt;
  logic [RUN_COORD_W-1:0]  run_x_r,    run_x_nxt;
  logic [RUN_COORD_W-1:0]  run_y_r,    run_y_nxt;
  logic [RUN_LEN_W-1:0]    run_len_r,  run_len_nxt;
  logic                    res_valid;

  logic                    in_fire;
  logic [CH_W-1:0]         ch;
  logic                    do_cmd;
  logic [COUNT_BITS-1:0]   cmd_n;
  logic [COUNT_BITS-1:0]   count_eff;
  logic [MUL_W-1:0]        count_mul;
  logic [COUNT_BITS-1:0]   count_sat;
  logic [3:0]              digit;
  logic [LEN_CMP_W-1:0]    len_wide;

  // A byte may enter whenever the result register is free this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign ch            = in_chan.ch;

  assign digit     = 4'(ch - CH_ZERO);
  assign count_eff = (count_r == '0) ? COUNT_BITS'(1) : count_r;

  // count * 10 + digit as shifts and adds, then saturate to all ones.
  assign count_mul = {1'b0, count_r, 3'b000} + {3'b000, count_r, 1'b0} + MUL_W'(digit);
  assign count_sat = (count_mul[MUL_W-1:COUNT_BITS] != '0) ? '1
                                                           : count_mul[COUNT_BITS-1:0];

  // Run length is the command count capped to the width of the result field.
  assign len_wide = LEN_CMP_W'(cmd_n);

  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    finished_nxt = finished_r;
    do_cmd       = 1'b0;
    cmd_n        = COUNT_BITS'(1);
    res_valid    = 1'b0;
    kind_nxt     = KIND_RUN;
    run_x_nxt    = RUN_COORD_W'(col_r);
    run_y_nxt    = RUN_COORD_W'(row_r);
    run_len_nxt  = (len_wide > LEN_CMP_W'({RUN_LEN_W{1'b1}})) ? '1
                                                               : len_wide[RUN_LEN_W-1:0];

    if (finished_r) begin
      // After the end only a NUL matters, and it wipes the slate clean.
      if (ch == CH_NUL) begin
        mode_nxt     = MODE_IDLE;
        count_nxt    = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        finished_nxt = 1'b0;
      end
    end else begin
      case (mode_r)
        MODE_COMMENT: begin
          if (ch == CH_NUL) begin
            do_cmd = 1'b1;
          end else if (ch == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_COUNT: begin
          if (is_digit(ch)) begin
            count_nxt = count_sat;
          end else begin
            // Any non-digit closes the count; unknown bytes just drop it.
            mode_nxt  = MODE_IDLE;
            count_nxt = '0;
            do_cmd    = 1'b1;
            cmd_n     = count_eff;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (ch == CH_NUL || is_token(ch)) begin
            do_cmd = 1'b1;
          end else if (is_digit(ch)) begin
            mode_nxt  = MODE_COUNT;
            count_nxt = COUNT_BITS'(digit);
          end else if (!is_space(ch)) begin
            mode_nxt = MODE_COMMENT;
          end
        end
      endcase

      if (do_cmd) begin
        case (ch)
          CH_B: begin
            col_nxt = col_r + COORD_BITS'(cmd_n);
          end
          CH_O: begin
            res_valid = 1'b1;
            col_nxt   = col_r + COORD_BITS'(cmd_n);
          end
          CH_DOLLAR: begin
            row_nxt = row_r + COORD_BITS'(cmd_n);
            col_nxt = '0;
          end
          CH_BANG, CH_NUL: begin
            res_valid    = 1'b1;
            finished_nxt = 1'b1;
            mode_nxt     = MODE_IDLE;
            count_nxt    = '0;
            kind_nxt     = KIND_END;
            run_x_nxt    = '0;
            run_y_nxt    = '0;
            run_len_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      count_r    <= '0;
      col_r      <= '0;
      row_r      <= '0;
      finished_r <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      finished_r <= finished_nxt;
    end
  end

  // Result valid: loaded on every accepted byte, cleared once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind_r    <= kind_nxt;
      run_x_r   <= run_x_nxt;
      run_y_r   <= run_y_nxt;
      run_len_r <= run_len_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = kind_r;
  assign out_chan.run_x      = run_x_r;
  assign out_chan.run_y      = run_y_r;
  assign out_chan.run_length = run_len_r;

  // Once the pattern has ended, no byte may produce another result.
  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && finished_r) |=> !out_valid_r)
    else $error("result produced after end of pattern");

  // An end beat waiting at the output implies the finished flag is held.
  a_end_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_END) |-> finished_r)
    else $error("end beat without finished flag");

  // A live run always covers at least one cell.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_RUN) |-> (run_len_r != '0))
    else $error("live run with zero length");

endmodule

>>> sim/rle_pattern_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// rle_pattern_decoder_core_tb: self-checking bench for the RLE pattern decoder
// Drives pattern text bytes into the decoder and checks every live run and end
// beat against a cycle-free software decoder that runs alongside it. A few
// short hand-written patterns come first, then random patterns under three
// stall profiles.
// ----------------------------------------------------------------------------
module rle_pattern_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  // About two thousand bytes, even under the heaviest stalls, finish well inside
  // this limit.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic                   kind;
    logic [RUN_COORD_W-1:0] run_x;
    logic [RUN_COORD_W-1:0] run_y;
    logic [RUN_LEN_W-1:0]   run_length;
  } run_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rpd_in_if  in_chan ();
  rpd_out_if out_chan ();

  rle_pattern_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Free-running 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  // Beats the decoder still owes, oldest first.
  run_beat_t   pending_runs[$];
  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;

  // Stall odds in percent for the byte sender and the result receiver.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  // Shadow copy of the scanner state, kept at the block's default widths.
  scan_mode_t                  shadow_mode;
  logic [COUNT_BITS_DEF-1:0]   shadow_count;
  logic [COORD_BITS_DEF-1:0]   shadow_col;
  logic [COORD_BITS_DEF-1:0]   shadow_row;
  logic                        shadow_done;

  // --------------------------------------------------------------------------
  // Software decoder. It is advanced once per accepted input beat and queues
  // whatever result that byte should produce.
  // --------------------------------------------------------------------------
  function automatic logic char_is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic clear_decoder();
    shadow_mode  = MODE_IDLE;
    shadow_count = '0;
    shadow_col   = '0;
    shadow_row   = '0;
    shadow_done  = 1'b0;
  endtask

  // The pattern is over: an end beat carries zeros in every other field.
  task automatic end_pattern();
    shadow_done  = 1'b1;
    shadow_mode  = MODE_IDLE;
    shadow_count = '0;
    pending_runs.push_back('{kind: KIND_END, run_x: '0, run_y: '0, run_length: '0});
  endtask

  // Carry out a command byte with a resolved run count. Any byte that is not
  // a command silently drops the count.
  task automatic apply_command(input logic [CH_W-1:0] c,
                               input logic [COUNT_BITS_DEF-1:0] n);
    case (c)
      CH_B: begin
        shadow_col = shadow_col + COORD_BITS_DEF'(n);
      end
      CH_O: begin
        pending_runs.push_back('{kind: KIND_RUN, run_x: shadow_col, run_y: shadow_row,
                                 run_length: n});
        shadow_col = shadow_col + COORD_BITS_DEF'(n);
      end
      CH_DOLLAR: begin
        shadow_row = shadow_row + COORD_BITS_DEF'(n);
        shadow_col = '0;
      end
      CH_BANG, CH_NUL: begin
        end_pattern();
      end
      default: begin
      end
    endcase
  endtask

  task automatic decode_char(input logic [CH_W-1:0] c);
    int unsigned grown;
    logic [COUNT_BITS_DEF-1:0] n;
    if (shadow_done) begin
      // Everything is ignored after the end, except a NUL that starts over.
      if (c == CH_NUL) clear_decoder();
    end else begin
      case (shadow_mode)
        MODE_COMMENT: begin
          if (c == CH_NUL) end_pattern();
          else if (c == CH_LF) shadow_mode = MODE_IDLE;
        end
        MODE_COUNT: begin
          if (char_is_digit(c)) begin
            // Saturate instead of wrapping once the count outgrows its width.
            grown = shadow_count * 10 + (c - CH_ZERO);
            shadow_count = (grown > {COUNT_BITS_DEF{1'b1}}) ? {COUNT_BITS_DEF{1'b1}}
                                                            : grown[COUNT_BITS_DEF-1:0];
          end else begin
            n = (shadow_count == '0) ? COUNT_BITS_DEF'(1) : shadow_count;
            shadow_mode  = MODE_IDLE;
            shadow_count = '0;
            apply_command(c, n);
          end
        end
        default: begin
          // Between tokens; the unused mode code lands here as well.
          shadow_mode = MODE_IDLE;
          if (c == CH_NUL) begin
            end_pattern();
          end else if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
          end else if (char_is_digit(c)) begin
            shadow_count = COUNT_BITS_DEF'(c - CH_ZERO);
            shadow_mode  = MODE_COUNT;
          end else if (c inside {CH_B, CH_O, CH_DOLLAR, CH_BANG}) begin
            apply_command(c, COUNT_BITS_DEF'(1));
          end else begin
            // Anything else opens a comment that runs to the newline.
            shadow_mode = MODE_COMMENT;
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte sender. It is entered and left at a falling edge. Valid stays high
  // across back-to-back beats and only drops when the sender chooses to idle.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [CH_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    // The byte is taken at this edge, so the decoder state moves here too.
    decode_char(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver. Ready is redrawn at every falling edge from the current
  // stall odds, and each accepted beat is checked at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_results
    run_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("beat with nothing pending: kind=%0d x=%0h y=%0h len=%0d",
                                  out_chan.kind, out_chan.run_x, out_chan.run_y,
                                  out_chan.run_length));
      end else begin
        want = pending_runs.pop_front();
        if (out_chan.kind !== want.kind || out_chan.run_x !== want.run_x ||
            out_chan.run_y !== want.run_y || out_chan.run_length !== want.run_length) begin
          report_mismatch($sformatf(
            "got kind=%0d x=%0h y=%0h len=%0d, want kind=%0d x=%0h y=%0h len=%0d",
            out_chan.kind, out_chan.run_x, out_chan.run_y, out_chan.run_length,
            want.kind, want.run_x, want.run_y, want.run_length));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------
  // Every command at least once, a zero count, whitespace, bytes after the end
  // (one of them 0xFF) and the silent NUL that clears the decoder afterwards.
  task automatic test_basic_tokens();
    send_text("o3b2o$0o\t!$");
    send_char(8'hFF);
    send_char(CH_NUL);
  endtask

  // A count that overflows its register and gives the longest run, then a
  // count that is dropped along with the stray byte that follows it.
  task automatic test_count_edges();
    send_text("99999o7xo");
  endtask

  // A high byte opens a comment, the newline closes it. A NUL inside a
  // comment and a NUL right after a count both end the pattern, and each is
  // followed by a second NUL that clears the state again.
  task automatic test_comment_lines();
    send_char(8'h80);
    send_text("o\n#");
    send_char(CH_NUL);
    send_char(CH_NUL);
    send_text("4");
    send_char(CH_NUL);
    send_char(CH_NUL);
  endtask

  // One random pattern: mostly well-formed count/command pairs, with some
  // whitespace, comment lines, dropped counts and raw noise mixed in. It is
  // closed by '!' or NUL, trailed by ignored bytes, and cleared by a NUL.
  task automatic send_random_pattern();
    int unsigned tokens;
    int unsigned sel;
    int unsigned digits;
    logic [CH_W-1:0] other;
    tokens = $urandom_range(40, 2);
    for (int k = 0; k < tokens; k++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        case ($urandom_range(5))
          0: send_char(CH_SPACE);
          1: send_char(CH_TAB);
          2: send_char(CH_LF);
          3: send_char(CH_VT);
          4: send_char(CH_FF);
          default: send_char(CH_CR);
        endcase
      end else if (sel < 94) begin
        // Most counts are short; a few are long enough to saturate.
        sel = $urandom_range(9);
        digits = (sel < 3) ? 0 : (sel < 8) ? $urandom_range(2, 1) : $urandom_range(6, 3);
        for (int i = 0; i < digits; i++) send_char(CH_ZERO + CH_W'($urandom_range(9)));
        if ($urandom_range(99) < 88 || digits == 0) begin
          case ($urandom_range(3))
            0: send_char(CH_B);
            3: send_char(CH_DOLLAR);
            default: send_char(CH_O);
          endcase
        end else begin
          // Dropped count: follow it with a byte that is not a command.
          other = CH_W'($urandom_range(255));
          while (char_is_digit(other) || other inside {CH_B, CH_O, CH_DOLLAR, CH_BANG, CH_NUL})
            other = CH_W'($urandom_range(255));
          send_char(other);
        end
      end else if (sel < 98) begin
        case ($urandom_range(2))
          0: send_char("#");
          1: send_char(8'h80 | CH_W'($urandom_range(127)));
          default: send_char("x");
        endcase
        for (int i = $urandom_range(6); i > 0; i--)
          send_char(CH_W'($urandom_range(8'h7E, 8'h20)));
        send_char(CH_LF);
      end else begin
        send_char(CH_W'($urandom_range(255)));
      end
    end
    send_char($urandom_range(1) ? CH_BANG : CH_NUL);
    for (int i = $urandom_range(4); i > 0; i--) send_char(CH_W'($urandom_range(255, 1)));
    send_char(CH_NUL);
  endtask

  task automatic test_random_patterns(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_pattern();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    out_chan.ready = 1'b0;
    clear_decoder();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver stalls heavily.
    src_idle_pct = 24;
    snk_idle_pct = 68;
    test_basic_tokens();
    test_count_edges();
    test_comment_lines();
    test_random_patterns(620);

    // Roles swapped: a hesitant sender and a mostly ready receiver.
    src_idle_pct = 68;
    snk_idle_pct = 24;
    test_random_patterns(620);

    // Full rate on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_patterns(600);

    in_chan.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    // A few more cycles to catch any stray beat behind the last one.
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rpd_pkg.sv
rtl/rpd_in_if.sv
rtl/rpd_out_if.sv
rtl/rle_pattern_decoder_core.sv
sim/rle_pattern_decoder_core_tb.sv
